### design/mbrprb_pkg.sv
// Shared types, constants and codes of the MBR partition record builder.
package mbrprb_pkg;

	// Field widths
	localparam int DATA_W    = 32;
	localparam int SPEC_W    = 41;
	localparam int SHIFT_W   = 4;
	localparam int TYPE_W    = 8;
	localparam int SLOT_W    = 2;
	localparam int SLOT_CNT_W = 3;
	localparam int BYTE_W    = 8;
	localparam int SEC_W     = 6;
	localparam int CYL_W     = 10;
	localparam int PADDR_W   = 3;

	// Layout constants
	localparam int SPT_DEFAULT = 63;
	localparam int MAX_SLOTS   = 4;
	localparam int PCT_FULL    = 100;
	localparam int PCT_W       = 7;
	localparam int CYL_LIMIT   = 1024;
	localparam int HEADS_MIN   = 8;
	localparam int HEADS_TOP   = 128;
	localparam int HEADS_CAP   = 255;

	// Reset value of the sector shift register
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);

	// Register index taken from the word address
	typedef enum logic {
		REG_DISK_SECTORS = 1'b0,
		REG_SECTOR_SHIFT = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PCT,
		ST_CLIP,
		ST_ZERO,
		ST_S_TRK,
		ST_S_CYL,
		ST_E_TRK,
		ST_E_CYL,
		ST_OUT
	} seq_state_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [DATA_W-1:0]  disk_sectors;
		logic [SHIFT_W-1:0] sector_shift;
	} cfg_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] rem;
	} div_rsp_t;

endpackage

### design/mbrprb_if.sv
// Request and result channel interfaces of the MBR partition record builder.
interface mbrprb_req_if import mbrprb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              first_of_table;
	logic [SPEC_W-1:0] size_spec;
	logic [TYPE_W-1:0] type_byte;

	modport source (output valid, first_of_table, size_spec, type_byte, input ready);
	modport sink (input valid, first_of_table, size_spec, type_byte, output ready);
endinterface

interface mbrprb_res_if import mbrprb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              valid_res;
	logic [SLOT_W-1:0] slot;
	logic [BYTE_W-1:0] first_head;
	logic [BYTE_W-1:0] start_sec_cyl;
	logic [BYTE_W-1:0] start_cyl_low;
	logic [TYPE_W-1:0] part_type;
	logic [BYTE_W-1:0] last_head;
	logic [BYTE_W-1:0] end_sec_cyl;
	logic [BYTE_W-1:0] end_cyl_low;
	logic [DATA_W-1:0] start_lba;
	logic [DATA_W-1:0] length_lba;

	modport source (output valid, valid_res, slot, first_head, start_sec_cyl, start_cyl_low,
		part_type, last_head, end_sec_cyl, end_cyl_low, start_lba, length_lba, input ready);
	modport sink (input valid, valid_res, slot, first_head, start_sec_cyl, start_cyl_low,
		part_type, last_head, end_sec_cyl, end_cyl_low, start_lba, length_lba, output ready);
endinterface

### design/mbr_partition_record_builder_core.sv
// Top level of the MBR partition record builder: sequencer, layout state and result register.
//
// Usage. Requests arrive on the req channel (first_of_table, size_spec, type_byte) and
// each one yields exactly one record on the res channel; valid_res is low and every other
// field zero when no partition was made. Both channels move a request on a rising edge
// with valid and ready high. The disk size and sector shift are written over the APB
// port at byte addresses 0 and 4; they are to be written only while the block is idle,
// which the block itself does not enforce. pready is always high.
// A request that is refused at once (table ended, fifth slot, disk full) goes from the
// check state straight to the output register. A partition needs four divisions on the
// shared bit-serial divider (start and end LBA to CHS); a percentage size adds one more
// division of the disk size. One request is worked on at a time, so a new request is
// taken only once the record of the last one has been loaded into the output register.
// While a record waits in the output register the next request is already accepted
// and worked on; it waits only for the final load if the receiver still stalls.
// Reset clears the layout to the first track, slot zero, table open, and sets the
// registers to a disk size of zero and a shift of 9. No clearing pass is needed.
module mbr_partition_record_builder_core import mbrprb_pkg::*; #(
	parameter int SECTORS_PER_TRACK = SPT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	mbrprb_req_if.sink         req,
	mbrprb_res_if.source       res
);

	localparam logic [DATA_W-1:0] SPT = DATA_W'(SECTORS_PER_TRACK);
	// Disk sizes from which the head count doubles again (the last step goes to 255)
	localparam logic [DATA_W-1:0] HT_8   = DATA_W'((CYL_LIMIT + 1) * SECTORS_PER_TRACK * HEADS_MIN);
	localparam logic [DATA_W-1:0] HT_16  = DATA_W'((CYL_LIMIT + 1) * SECTORS_PER_TRACK * HEADS_MIN * 2);
	localparam logic [DATA_W-1:0] HT_32  = DATA_W'((CYL_LIMIT + 1) * SECTORS_PER_TRACK * HEADS_MIN * 4);
	localparam logic [DATA_W-1:0] HT_64  = DATA_W'((CYL_LIMIT + 1) * SECTORS_PER_TRACK * HEADS_MIN * 8);
	localparam logic [DATA_W-1:0] HT_128 = DATA_W'((CYL_LIMIT + 1) * SECTORS_PER_TRACK * HEADS_TOP);

	cfg_t       cfg;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	seq_state_t state_q, state_d;

	// Layout state
	logic [DATA_W-1:0]     next_q;
	logic [SLOT_CNT_W-1:0] slot_q;
	logic                  ended_q;

	// Working registers of the current request
	logic              first_q;
	logic [SPEC_W-1:0] spec_q;
	logic [TYPE_W-1:0] type_q;
	logic [DATA_W-1:0] n_q;
	logic [BYTE_W-1:0] heads_q;
	logic [DATA_W-1:0] end_lba_q;
	logic [SEC_W-1:0]  sec_s_q, sec_e_q;
	logic [BYTE_W-1:0] head_s_q, head_e_q;
	logic [CYL_W-1:0]  cyl_s_q, cyl_e_q;
	logic              ok_q;

	// Output register
	logic              out_valid_q;
	logic              out_ok_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [BYTE_W-1:0] out_shead_q, out_ssc_q, out_scl_q;
	logic [BYTE_W-1:0] out_ehead_q, out_esc_q, out_ecl_q;
	logic [TYPE_W-1:0] out_type_q;
	logic [DATA_W-1:0] out_start_q, out_len_q;

	// Combinational helpers
	logic [DATA_W-1:0]     next_eff;
	logic [SLOT_CNT_W-1:0] slot_eff;
	logic                  ended_eff;
	logic                  chk_bad;
	logic [SPEC_W-1:0]     shifted;
	logic [DATA_W-1:0]     n_raw;
	logic [DATA_W+PCT_W-1:0] pct_prod;
	logic [DATA_W:0]       span;
	logic [BYTE_W-1:0]     heads_w;
	logic                  out_load;

	mbrprb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbrprb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// A restart request opens a fresh table before the checks.
	assign next_eff  = first_q ? SPT : next_q;
	assign slot_eff  = first_q ? '0 : slot_q;
	assign ended_eff = first_q ? 1'b0 : ended_q;
	assign chk_bad   = ended_eff || (slot_eff >= SLOT_CNT_W'(MAX_SLOTS)) ||
		(next_eff >= cfg.disk_sectors);

	// Sector count from the byte size, saturated to 32 bits.
	assign shifted = spec_q >> cfg.sector_shift;
	assign n_raw   = (|shifted[SPEC_W-1:DATA_W]) ? '1 : shifted[DATA_W-1:0];

	// Percentage times one hundredth of the disk.
	assign pct_prod = {{DATA_W{1'b0}}, n_q[PCT_W-1:0]} * {{PCT_W{1'b0}}, div_rsp.quot};

	// End of the partition for the clip test.
	assign span = {1'b0, next_q} + {1'b0, n_q};

	// Head count from the disk size.
	always_comb begin
		priority if (cfg.disk_sectors < HT_8)   heads_w = BYTE_W'(HEADS_MIN);
		else if (cfg.disk_sectors < HT_16)      heads_w = BYTE_W'(HEADS_MIN * 2);
		else if (cfg.disk_sectors < HT_32)      heads_w = BYTE_W'(HEADS_MIN * 4);
		else if (cfg.disk_sectors < HT_64)      heads_w = BYTE_W'(HEADS_MIN * 8);
		else if (cfg.disk_sectors < HT_128)     heads_w = BYTE_W'(HEADS_TOP);
		else                                    heads_w = BYTE_W'(HEADS_CAP);
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	// Sequencer: next state, divider requests and input ready.
	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = next_q;
		div_req.divisor  = SPT;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (chk_bad) begin
					state_d = ST_OUT;
				end else if (n_raw < DATA_W'(PCT_FULL)) begin
					div_req.start    = 1'b1;
					div_req.dividend = cfg.disk_sectors;
					div_req.divisor  = DATA_W'(PCT_FULL);
					state_d          = ST_PCT;
				end else begin
					state_d = ST_CLIP;
				end
			end
			ST_PCT: begin
				if (div_rsp.done) state_d = ST_CLIP;
			end
			ST_CLIP: begin
				state_d = ST_ZERO;
			end
			ST_ZERO: begin
				if (n_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_S_TRK;
				end
			end
			ST_S_TRK: begin
				div_req.dividend = div_rsp.quot;
				div_req.divisor  = {{(DATA_W-BYTE_W){1'b0}}, heads_q};
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = ST_S_CYL;
				end
			end
			ST_S_CYL: begin
				div_req.dividend = end_lba_q;
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = ST_E_TRK;
				end
			end
			ST_E_TRK: begin
				div_req.dividend = div_rsp.quot;
				div_req.divisor  = {{(DATA_W-BYTE_W){1'b0}}, heads_q};
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = ST_E_CYL;
				end
			end
			ST_E_CYL: begin
				if (div_rsp.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Layout state: restart, table end and advance after a record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q  <= SPT;
			slot_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			if (state_q == ST_CHECK) begin
				next_q  <= next_eff;
				slot_q  <= slot_eff;
				ended_q <= chk_bad;
			end else if (state_q == ST_ZERO && n_q == '0) begin
				ended_q <= 1'b1;
			end else if (out_load && ok_q) begin
				next_q <= next_q + n_q;
				slot_q <= slot_q + SLOT_CNT_W'(1);
			end
		end
	end

	// Working registers of the request in hand.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			first_q <= req.first_of_table;
			spec_q  <= req.size_spec;
			type_q  <= req.type_byte;
		end
		unique case (state_q)
			ST_CHECK: begin
				ok_q <= 1'b0;
				n_q  <= (n_raw == DATA_W'(PCT_FULL)) ? cfg.disk_sectors : n_raw;
			end
			ST_PCT: begin
				if (div_rsp.done) n_q <= pct_prod[DATA_W-1:0];
			end
			ST_CLIP: begin
				if (span > {1'b0, cfg.disk_sectors}) n_q <= cfg.disk_sectors - next_q;
			end
			ST_ZERO: begin
				heads_q   <= heads_w;
				end_lba_q <= next_q + n_q - DATA_W'(1);
			end
			ST_S_TRK: begin
				if (div_rsp.done) sec_s_q <= div_rsp.rem[SEC_W-1:0] + SEC_W'(1);
			end
			ST_S_CYL: begin
				if (div_rsp.done) begin
					head_s_q <= div_rsp.rem[BYTE_W-1:0];
					cyl_s_q  <= div_rsp.quot[CYL_W-1:0];
				end
			end
			ST_E_TRK: begin
				if (div_rsp.done) sec_e_q <= div_rsp.rem[SEC_W-1:0] + SEC_W'(1);
			end
			ST_E_CYL: begin
				if (div_rsp.done) begin
					head_e_q <= div_rsp.rem[BYTE_W-1:0];
					cyl_e_q  <= div_rsp.quot[CYL_W-1:0];
					ok_q     <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; a refused request gives an all-zero record.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q    <= ok_q;
			out_slot_q  <= ok_q ? slot_q[SLOT_W-1:0] : '0;
			out_shead_q <= ok_q ? head_s_q : '0;
			out_ssc_q   <= ok_q ? {cyl_s_q[CYL_W-1:BYTE_W], sec_s_q} : '0;
			out_scl_q   <= ok_q ? cyl_s_q[BYTE_W-1:0] : '0;
			out_type_q  <= ok_q ? type_q : '0;
			out_ehead_q <= ok_q ? head_e_q : '0;
			out_esc_q   <= ok_q ? {cyl_e_q[CYL_W-1:BYTE_W], sec_e_q} : '0;
			out_ecl_q   <= ok_q ? cyl_e_q[BYTE_W-1:0] : '0;
			out_start_q <= ok_q ? next_q : '0;
			out_len_q   <= ok_q ? n_q : '0;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.valid_res     = out_ok_q;
	assign res.slot          = out_slot_q;
	assign res.first_head    = out_shead_q;
	assign res.start_sec_cyl = out_ssc_q;
	assign res.start_cyl_low = out_scl_q;
	assign res.part_type     = out_type_q;
	assign res.last_head     = out_ehead_q;
	assign res.end_sec_cyl   = out_esc_q;
	assign res.end_cyl_low   = out_ecl_q;
	assign res.start_lba     = out_start_q;
	assign res.length_lba    = out_len_q;

`ifndef SYNTHESIS
	// A refused request carries an all-zero record.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.valid_res |-> res.slot == '0 && res.start_lba == '0 &&
		res.length_lba == '0 && res.part_type == '0)
		else $error("invalid record with non-zero fields");

	// A record is never empty and never runs past the disk end.
	a_record_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.valid_res |-> res.length_lba != '0 &&
		({1'b0, res.start_lba} + {1'b0, res.length_lba}) <= {1'b0, cfg.disk_sectors})
		else $error("record outside the disk");

	// The divider reports only while the sequencer waits on it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_PCT || state_q == ST_S_TRK ||
		state_q == ST_S_CYL || state_q == ST_E_TRK || state_q == ST_E_CYL)
		else $error("divider finished outside a wait state");

	// An accepted request goes straight to the checks.
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_CHECK)
		else $error("accepted request not checked");
`endif

endmodule

### design/mbrprb_cfg.sv
// APB register block holding the disk size and the sector shift.
module mbrprb_cfg import mbrprb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [DATA_W-1:0]  disk_q;
	logic [SHIFT_W-1:0] shift_q;
	reg_idx_t           idx;
	logic               wr_en;

	// Word address selects the register; byte offset bits are ignored.
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q  <= '0;
			shift_q <= SHIFT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_DISK_SECTORS: disk_q  <= pwdata;
				REG_SECTOR_SHIFT: shift_q <= pwdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (idx)
			REG_DISK_SECTORS: prdata = disk_q;
			REG_SECTOR_SHIFT: prdata = {{(DATA_W-SHIFT_W){1'b0}}, shift_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.disk_sectors = disk_q;
	assign cfg.sector_shift = shift_q;

endmodule

### design/mbrprb_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module mbrprb_div import mbrprb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   part;
	logic [DATA_W+1:0] trial;
	logic              fits;

	// Partial remainder with the next dividend bit, less the divisor.
	assign part  = {acc_q, quo_q[DATA_W-1]};
	assign trial = {1'b0, part} - {2'b00, dvs_q};
	assign fits  = !trial[DATA_W+1];

	// Control: busy for one step per dividend bit, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DATA_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend shifts out at the top while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= fits ? trial[DATA_W-1:0] : part[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = acc_q;

endmodule

### tb/sv/tb_mbr_partition_record_builder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of the MBR partition record builder: directed table, random tables, APB set-up.
module tb_mbr_partition_record_builder_core import mbrprb_pkg::*; ();

	localparam int SPT         = SPT_DEFAULT;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 143;

	// One partition request as the sender presents it
	typedef struct packed {
		logic              first;
		logic [SPEC_W-1:0] spec;
		logic [TYPE_W-1:0] ptype;
	} part_req_t;

	// One partition record as the block returns it
	typedef struct packed {
		logic              valid_res;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] s_head;
		logic [BYTE_W-1:0] s_sc;
		logic [BYTE_W-1:0] s_cl;
		logic [TYPE_W-1:0] ptype;
		logic [BYTE_W-1:0] e_head;
		logic [BYTE_W-1:0] e_sc;
		logic [BYTE_W-1:0] e_cl;
		logic [DATA_W-1:0] s_lba;
		logic [DATA_W-1:0] len;
	} part_rec_t;

	// A row of the directed table; zero_rec marks a request whose record must be all zero
	typedef struct packed {
		logic               set_cfg;
		logic [DATA_W-1:0]  disk;
		logic [SHIFT_W-1:0] shift;
		logic               first;
		logic [SPEC_W-1:0]  spec;
		logic [TYPE_W-1:0]  ptype;
		logic               zero_rec;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	mbrprb_req_if req_ch ();
	mbrprb_res_if res_ch ();

	mbr_partition_record_builder_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.res     (res_ch)
	);

	// Configuration and layout state as the predictor sees them
	logic [DATA_W-1:0]     cfg_disk;
	logic [SHIFT_W-1:0]    cfg_shift;
	logic [DATA_W-1:0]     lay_next;
	logic [SLOT_CNT_W-1:0] lay_slots;
	logic                  lay_closed;

	part_rec_t records_due [$];
	int        err_count;
	logic      steady;
	dir_row_t  dir_tab [0:22];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Head count: start at eight and double while the cylinder count would pass 1024.
	function automatic logic [DATA_W-1:0] heads_for(input logic [DATA_W-1:0] disk);
		logic [DATA_W-1:0] h;
		h = HEADS_MIN;
		while (h <= HEADS_TOP && disk / (h * SPT) > CYL_LIMIT)
			h = h * 2;
		return (h > HEADS_TOP) ? HEADS_CAP : h;
	endfunction

	// Packs {head, sector with cylinder bits 9:8, cylinder low byte} for one sector.
	function automatic logic [3*BYTE_W-1:0] lba_to_chs(input logic [DATA_W-1:0] lba,
			input logic [DATA_W-1:0] heads);
		logic [DATA_W-1:0] tracks;
		logic [DATA_W-1:0] sec;
		logic [DATA_W-1:0] cyl;
		logic [DATA_W-1:0] hd;
		logic [DATA_W-1:0] sc;
		tracks = lba / SPT;
		sec    = 1 + lba % SPT;
		cyl    = tracks / heads;
		hd     = tracks % heads;
		sc     = sec | ((cyl >> 2) & 32'hC0);
		return {hd[BYTE_W-1:0], sc[BYTE_W-1:0], cyl[BYTE_W-1:0]};
	endfunction

	// Predicts the record for one request and advances the layout.
	function automatic part_rec_t layout_record(input part_req_t rq);
		part_rec_t         r;
		logic [63:0]       q;
		logic [DATA_W-1:0] n;
		logic [DATA_W-1:0] hd;
		r = '0;
		if (rq.first) begin
			lay_next   = SPT;
			lay_slots  = '0;
			lay_closed = 1'b0;
		end
		if (lay_closed || lay_slots >= MAX_SLOTS || lay_next >= cfg_disk) begin
			lay_closed = 1'b1;
			return r;
		end
		q = 64'(rq.spec) >> cfg_shift;
		n = (q > 64'hFFFF_FFFF) ? '1 : q[DATA_W-1:0];
		// Small counts are a percentage of the disk; exactly 100 is the whole disk.
		if (n <= PCT_FULL)
			n = (n == PCT_FULL) ? cfg_disk : n * (cfg_disk / PCT_FULL);
		if (64'(lay_next) + 64'(n) > 64'(cfg_disk))
			n = cfg_disk - lay_next;
		if (n == 0) begin
			lay_closed = 1'b1;
			return r;
		end
		hd = heads_for(cfg_disk);
		r.valid_res = 1'b1;
		r.slot      = lay_slots[SLOT_W-1:0];
		{r.s_head, r.s_sc, r.s_cl} = lba_to_chs(lay_next, hd);
		r.ptype     = rq.ptype;
		{r.e_head, r.e_sc, r.e_cl} = lba_to_chs(lay_next + n - 1, hd);
		r.s_lba     = lay_next;
		r.len       = n;
		lay_next    = lay_next + n;
		lay_slots   = lay_slots + SLOT_CNT_W'(1);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	task automatic cmp_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Compares the record on the result channel with the oldest expectation.
	task automatic check_record(input part_rec_t want);
		cmp_field("valid_res", DATA_W'(res_ch.valid_res), DATA_W'(want.valid_res));
		cmp_field("slot", DATA_W'(res_ch.slot), DATA_W'(want.slot));
		cmp_field("first_head", DATA_W'(res_ch.first_head), DATA_W'(want.s_head));
		cmp_field("start_sec_cyl", DATA_W'(res_ch.start_sec_cyl), DATA_W'(want.s_sc));
		cmp_field("start_cyl_low", DATA_W'(res_ch.start_cyl_low), DATA_W'(want.s_cl));
		cmp_field("part_type", DATA_W'(res_ch.part_type), DATA_W'(want.ptype));
		cmp_field("last_head", DATA_W'(res_ch.last_head), DATA_W'(want.e_head));
		cmp_field("end_sec_cyl", DATA_W'(res_ch.end_sec_cyl), DATA_W'(want.e_sc));
		cmp_field("end_cyl_low", DATA_W'(res_ch.end_cyl_low), DATA_W'(want.e_cl));
		cmp_field("start_lba", res_ch.start_lba, want.s_lba);
		cmp_field("length_lba", res_ch.length_lba, want.len);
	endtask

	// Presents one request, with random idle cycles ahead of it, and books its record.
	task automatic send_request(input part_req_t rq, input logic zero_rec);
		part_rec_t r;
		while (!steady && $urandom_range(99) < 25) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.first_of_table <= rq.first;
		req_ch.size_spec      <= rq.spec;
		req_ch.type_byte      <= rq.ptype;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = layout_record(rq);
		records_due.push_back(zero_rec ? part_rec_t'('0) : r);
	endtask

	// Holds the sender off until every booked record has come back.
	task automatic wait_all_records();
		req_ch.valid <= 1'b0;
		while (records_due.size() != 0)
			@(posedge clk);
	endtask

	// APB write of one register followed by a read back of it.
	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] mask;
		mask = (idx == REG_DISK_SECTORS) ? '1 : DATA_W'((1 << SHIFT_W) - 1);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & mask) !== (data & mask))
			report_mismatch($sformatf("register %s read %0h want %0h", idx.name(),
				prdata & mask, data & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for the block to go idle, then sets the disk size and sector shift.
	task automatic program_disk(input logic [DATA_W-1:0] disk, input logic [SHIFT_W-1:0] shift);
		wait_all_records();
		reg_write(REG_DISK_SECTORS, disk);
		reg_write(REG_SECTOR_SHIFT, DATA_W'(shift));
		cfg_disk  = disk;
		cfg_shift = shift;
	endtask

	// Result side: random back-pressure, record checks and the stall watchdog.
	initial begin
		int        quiet_cycles;
		part_rec_t want;
		quiet_cycles = 0;
		res_ch.ready = 1'b0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (records_due.size() == 0) begin
					report_mismatch("record with no request outstanding");
				end else begin
					want = records_due.pop_front();
					check_record(want);
				end
			end
			if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			res_ch.ready <= steady || ($urandom_range(99) >= 25);
		end
		$display("tb_mbr_partition_record_builder_core: errors");
		$finish;
	end

	// Stimulus: directed table first, then random tables under changing disk settings.
	initial begin
		part_req_t         rq;
		logic [DATA_W-1:0] n;
		logic [63:0]       wide;
		int                tab_pos;
		int                tab_len;
		int                sel;
		err_count  = 0;
		steady     = 1'b0;
		cfg_disk   = '0;
		cfg_shift  = SHIFT_RESET;
		lay_next   = SPT;
		lay_slots  = '0;
		lay_closed = 1'b0;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		req_ch.valid          = 1'b0;
		req_ch.first_of_table = 1'b0;
		req_ch.size_spec      = '0;
		req_ch.type_byte      = '0;

		dir_tab = '{
			// Reset settings: a zero disk is full at once, then the table stays ended.
			'{1'b0, 32'd0, 4'd0, 1'b1, 41'h1FF_FFFF_FFFF, 8'hFF, 1'b1},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd25600, 8'h07, 1'b1},
			// Whole disk by percentage, clipped at the disk end; then disk full.
			'{1'b1, 32'd100000, 4'd9, 1'b1, 41'd51200, 8'h83, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd512, 8'h07, 1'b1},
			// Zero size ends the table, and it stays ended.
			'{1'b0, 32'd0, 4'd0, 1'b1, 41'd0, 8'h83, 1'b1},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd512, 8'h0C, 1'b1},
			// One percent, a plain count just above the percent range, then 99 percent clipped.
			'{1'b0, 32'd0, 4'd0, 1'b1, 41'd512, 8'h0C, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd51712, 8'h0B, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd51199, 8'h05, 1'b0},
			// Four records fill the table; the fifth and the one after are refused.
			'{1'b0, 32'd0, 4'd0, 1'b1, 41'd102400, 8'h01, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd102400, 8'h04, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd102400, 8'h06, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd102400, 8'h0E, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd102400, 8'h07, 1'b1},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd512, 8'h07, 1'b1},
			// Largest disk with 4 KiB sectors: 255 heads, cylinders above 1023.
			'{1'b1, 32'hFFFF_FFFF, 4'd12, 1'b1, 41'h1FF_FFFF_FFFF, 8'h42, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd204800, 8'hAA, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'h1FF_FFFF_FFFF, 8'h55, 1'b0},
			// Shift of zero: the count saturates at 32 bits and is clipped.
			'{1'b1, 32'hFFFF_FFFF, 4'd0, 1'b1, 41'h1FF_FFFF_FFFF, 8'h00, 1'b0},
			'{1'b0, 32'd0, 4'd0, 1'b0, 41'd0, 8'h12, 1'b1},
			// Tiny disk, largest shift: one percent rounds to nothing, the whole disk clips to one sector.
			'{1'b1, 32'd64, 4'd15, 1'b1, 41'd32768, 8'h0C, 1'b1},
			'{1'b0, 32'd0, 4'd0, 1'b1, 41'd3276800, 8'h0C, 1'b0},
			// Disk no larger than the first track.
			'{1'b1, 32'd63, 4'd9, 1'b1, 41'd512, 8'h0C, 1'b1}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_cfg)
				program_disk(dir_tab[i].disk, dir_tab[i].shift);
			rq = '{dir_tab[i].first, dir_tab[i].spec, dir_tab[i].ptype};
			send_request(rq, dir_tab[i].zero_rec);
		end

		// Random tables: mostly well-formed layouts, with stray restarts and raw sizes.
		tab_pos = 0;
		tab_len = 4;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 5)
				0: n = $urandom_range(5000, 64);
				1: n = $urandom_range(2000000, 5000);
				2: n = $urandom;
				3: n = '1;
				default: n = $urandom_range(200, 0);
			endcase
			program_disk(n, (ph < 8) ? SHIFT_W'($urandom_range(12, 9))
				: SHIFT_W'($urandom_range(15, 0)));
			steady = (ph == 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == PHASE_ITEMS / 2)
					wait_all_records();
				rq.first = (tab_pos == 0) || ($urandom_range(29) == 0);
				tab_pos++;
				if (tab_pos >= tab_len) begin
					tab_pos = 0;
					tab_len = $urandom_range(6, 2);
				end
				sel = $urandom_range(99);
				if (sel < 30)
					n = $urandom_range(PCT_FULL, 0);
				else if (sel < 75)
					n = $urandom_range(cfg_disk / 3 + 1, 1);
				else if (sel < 85)
					n = $urandom_range(1) ? cfg_disk : $urandom;
				if (sel < 85)
					wide = (64'(n) << cfg_shift)
						| ({32'd0, $urandom} & ((64'd1 << cfg_shift) - 64'd1));
				else
					wide = {$urandom, $urandom};
				rq.spec  = wide[SPEC_W-1:0];
				rq.ptype = TYPE_W'($urandom);
				send_request(rq, 1'b0);
			end
		end
		steady = 1'b0;

		wait_all_records();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_mbr_partition_record_builder_core: clean");
		else
			$display("tb_mbr_partition_record_builder_core: errors");
		$finish;
	end

endmodule

### filelist.f
design/mbrprb_pkg.sv
design/mbrprb_if.sv
design/mbrprb_cfg.sv
design/mbrprb_div.sv
design/mbr_partition_record_builder_core.sv
tb/sv/tb_mbr_partition_record_builder_core.sv
